### rtl/core/bat_pkg.sv
// Shared types and constants for the breakpoint address table.
// Holds the request codes, the beat payload structs and the controller/datapath bundles.
// No dependencies.
`timescale 1ns / 1ps

package bat_pkg;

   // Request codes carried in the req_type field.
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_CHECK  = 2'd2;

   // Width of the count fields in a result beat.
   localparam int COUNT_W = 5;
   localparam int ADDR_W  = 16;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ADDR_W-1:0] address;
   } bat_req_beat_type;

   typedef struct packed {
      logic               hit;
      logic               status;
      logic [COUNT_W-1:0] removed_count;
      logic [COUNT_W-1:0] entry_count;
   } bat_rsp_beat_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // latch the request beat and clear the scan pointers
      logic rd_issue;  // read the table entry at the read pointer
      logic eval;      // compare the read entry and advance the scan
      logic finish;    // commit the table update and load the result register
   } bat_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] kind;       // request code of the item in flight
      logic       scan_done;  // read pointer has reached the entry count
      logic       out_free;   // result register can take a beat this cycle
   } bat_stat_type;

endpackage

### rtl/core/bat_stream_if.sv
// Valid/ready channel used for the request and result sides of the table.
// The payload type is set per instance; no other dependencies.
`timescale 1ns / 1ps

interface bat_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/bat_ctrl.sv
// Controller for the breakpoint address table: sequences accept, scan and finish.
// Depends on bat_pkg for the command and status bundles and the request codes.
`timescale 1ns / 1ps

module bat_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bat_pkg::bat_stat_type stat,
   output bat_pkg::bat_cmd_type  cmd
);
   import bat_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      scan_kind;

   // Only delete and check walk the table; other codes go straight to finish.
   assign scan_kind = (stat.kind == REQ_DELETE) || (stat.kind == REQ_CHECK);

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.accept   = 1'b1;
               req_ready_in = 1'b0;
               state_in     = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (!scan_kind || stat.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            cmd.eval = 1'b1;
            state_in = ST_SCAN_RD;
         end
         ST_FINISH: begin
            // Hold here while the previous result beat is still waiting.
            if (stat.out_free) begin
               cmd.finish   = 1'b1;
               req_ready_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
         end
      endcase
   end

   // State and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

### rtl/core/bat_datapath.sv
// Datapath for the breakpoint address table: entry memory, count, scan pointers
// and the result register. Depends on bat_pkg for beats, bundles and request codes.
`timescale 1ns / 1ps

module bat_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bat_pkg::bat_cmd_type      cmd,
   output bat_pkg::bat_stat_type     stat,
   input  bat_pkg::bat_req_beat_type req_beat,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bat_pkg::bat_rsp_beat_type rsp_beat
);
   import bat_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ADDR_W-1:0]  mem [DEPTH];
   logic [ADDR_W-1:0]  rdata_ff;

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [1:0]         kind_ff, kind_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bat_rsp_beat_type   rsp_ff, rsp_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [ADDR_W-1:0]  mem_wdata;

   logic               full;
   logic [CW-1:0]      removed;
   logic [CW+COUNT_W-1:0] count_ext;
   logic [CW+COUNT_W-1:0] removed_ext;

   assign full = (count_ff == CW'(DEPTH));

   // Status back to the controller.
   assign stat.kind      = kind_ff;
   assign stat.scan_done = (rd_ptr_ff == count_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // Next values for the request, scan and result registers.
   always_comb begin
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_ptr_ff[AW-1:0];
      mem_wdata    = rdata_ff;
      removed      = '0;

      if (cmd.accept) begin
         kind_in   = req_beat.req_type;
         addr_in   = req_beat.address;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         hit_in    = 1'b0;
      end

      // One entry per scan step: a match sets hit, and on a delete every
      // entry that does not match is copied down to the write pointer.
      if (cmd.eval) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         if (rdata_ff == addr_ff) begin
            hit_in = 1'b1;
         end else if (kind_ff == REQ_DELETE) begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_ff[AW-1:0];
            mem_wdata = rdata_ff;
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Commit the table update and build the result beat.
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         case (kind_ff)
            REQ_ADD: begin
               if (!full) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[AW-1:0];
                  mem_wdata = addr_ff;
                  count_in  = count_ff + 1'b1;
               end
               rsp_in.status = full;
            end
            REQ_DELETE: begin
               removed  = count_ff - wr_ptr_ff;
               count_in = wr_ptr_ff;
            end
            REQ_CHECK: begin
               rsp_in.hit = hit_ff;
            end
            default: begin
            end
         endcase
         removed_ext          = {{COUNT_W{1'b0}}, removed};
         count_ext            = {{COUNT_W{1'b0}}, count_in};
         rsp_in.removed_count = removed_ext[COUNT_W-1:0];
         rsp_in.entry_count   = count_ext[COUNT_W-1:0];
      end else begin
         removed_ext = '0;
         count_ext   = '0;
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      kind_ff   <= kind_in;
      addr_ff   <= addr_in;
      hit_ff    <= hit_in;
      rsp_ff    <= rsp_in;
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_issue) begin
         rdata_ff <= mem[rd_ptr_ff[AW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

### rtl/core/breakpoint_address_table.sv
// Breakpoint address table: a packed, ordered list of up to DEPTH 16-bit addresses.
// Each request beat on req_chan carries req_type (add, delete all matching, check)
// and an address; every request gives exactly one result beat on rsp_chan with hit,
// status (add dropped, table full), removed_count and entry_count after the request.
// Entries live in a memory with one write and one registered read port; a delete or
// check walks the valid entries one at a time, a read state and an evaluate state per
// entry, and a delete copies the survivors down in the same walk so the order is kept.
// One request is in flight at a time, so the next request can be taken in the cycle
// after the previous result is loaded; the walk over the entry memory sets the rate.
// The result register lets a new request be accepted and worked on while the last
// result waits; if the receiver stalls, the next result is held back until the
// register frees. Reset empties the table (entry count zero) and drops any pending
// result; entry contents need no clearing.
// Depends on bat_pkg, bat_stream_if, bat_ctrl and bat_datapath.
`timescale 1ns / 1ps

module breakpoint_address_table #(
   parameter int DEPTH = 16
) (
   input logic          clock,
   input logic          reset,
   bat_stream_if.sink   req_chan,
   bat_stream_if.source rsp_chan
);
   import bat_pkg::*;

   bat_cmd_type      cmd;
   bat_stat_type     stat;
   bat_req_beat_type req_beat;
   bat_rsp_beat_type rsp_beat;
   logic             req_ready;
   logic             rsp_valid;

   assign req_beat = req_chan.payload;

   // Sequencer for accept, scan and finish.
   bat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table storage, scan pointers and result register.
   bat_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_beat  (rsp_beat)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_beat;

endmodule

### sim/breakpoint_address_table_test.sv
// Self-checking testbench for the breakpoint address table: directed and random
// add, delete and check requests, with idle gaps and back-pressure on both channels.
// Depends on bat_pkg, bat_stream_if and breakpoint_address_table.
`timescale 1ns / 1ps

module breakpoint_address_table_test;
   import bat_pkg::*;

   localparam int TABLE_DEPTH    = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 48;
   localparam int IDLE_PERCENT   = 27;
   localparam int HOLD_CYCLES    = 300;
   localparam int POOL_SIZE      = 8;

   // Code 3 is not a request kind; the block must answer it without effect.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic clock;
   logic reset;

   bat_stream_if #(.payload_type(bat_req_beat_type)) req_chan ();
   bat_stream_if #(.payload_type(bat_rsp_beat_type)) rsp_chan ();

   breakpoint_address_table #(
      .DEPTH(TABLE_DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Shadow copy of the table, updated in acceptance order.
   logic [15:0]      bp_table [TABLE_DEPTH];
   int               bp_count;
   bat_rsp_beat_type expected_rsp [$];
   logic [15:0]      addr_pool [POOL_SIZE];

   int          error_count;
   int          idle_cycles;
   int unsigned hold_request;
   bit          quiet_mode;

   // Free-running clock, 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one request to the shadow table and returns the beat it should give.
   function automatic bat_rsp_beat_type apply_request(input bat_req_beat_type req);
      bat_rsp_beat_type rsp;
      int               kept;
      rsp  = '0;
      kept = 0;
      case (req.req_type)
         REQ_ADD: begin
            if (bp_count < TABLE_DEPTH) begin
               bp_table[bp_count] = req.address;
               bp_count++;
            end else begin
               rsp.status = 1'b1;
            end
         end
         REQ_DELETE: begin
            // Survivors move down so the order of the table is kept.
            for (int i = 0; i < bp_count; i++) begin
               if (bp_table[i] != req.address) begin
                  bp_table[kept] = bp_table[i];
                  kept++;
               end
            end
            rsp.removed_count = COUNT_W'(bp_count - kept);
            bp_count = kept;
         end
         REQ_CHECK: begin
            for (int i = 0; i < bp_count; i++) begin
               if (bp_table[i] == req.address) rsp.hit = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp.entry_count = COUNT_W'(bp_count);
      return rsp;
   endfunction

   // Offers one request beat and waits until the block takes it.
   task automatic send_request(input logic [1:0] kind, input logic [15:0] addr);
      bat_req_beat_type beat;
      beat.req_type = kind;
      beat.address  = addr;
      @(negedge clock);
      if (!quiet_mode) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= beat;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      expected_rsp.push_back(apply_request(beat));
   endtask

   // Draws one request, mostly on a small address pool so that hits and deletes match.
   task automatic send_random_request(input int add_weight);
      int          pick;
      logic [1:0]  kind;
      logic [15:0] addr;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         kind = REQ_UNUSED;
      end else if (pick < 4 + add_weight) begin
         kind = REQ_ADD;
      end else if (pick < 4 + add_weight + (96 - add_weight) / 2) begin
         kind = REQ_DELETE;
      end else begin
         kind = REQ_CHECK;
      end
      if ($urandom_range(0, 99) < 2) begin
         addr_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom);
      end
      if ($urandom_range(0, 99) < 75) begin
         addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         addr = 16'($urandom);
      end
      send_request(kind, addr);
   endtask

   // Stops offering beats, then waits until every expected result has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Empty table, single-entry table and the address extremes.
   task automatic test_sparse_table();
      send_request(REQ_CHECK, 16'h0000);
      send_request(REQ_DELETE, 16'hFFFF);
      send_request(REQ_UNUSED, 16'hFFFF);
      send_request(REQ_ADD, 16'h1234);
      send_request(REQ_DELETE, 16'h4321);
      send_request(REQ_CHECK, 16'h1234);
      send_request(REQ_DELETE, 16'h1234);
   endtask

   // Fill with duplicates, overflow the table, then remove a repeated address.
   task automatic test_full_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i % 5 == 0) begin
            send_request(REQ_ADD, 16'h0000);
         end else if (i % 5 == 1) begin
            send_request(REQ_ADD, 16'hFFFF);
         end else begin
            send_request(REQ_ADD, 16'(16'h0100 * i + 16'h55));
         end
      end
      send_request(REQ_ADD, 16'hAAAA);
      send_request(REQ_CHECK, 16'hAAAA);
      send_request(REQ_DELETE, 16'h0000);
      send_request(REQ_CHECK, 16'hFFFF);
   endtask

   // Random traffic in blocks that lean toward filling or draining the table.
   task automatic test_random_traffic(input int item_total);
      int add_weight;
      add_weight = 45;
      for (int i = 0; i < item_total; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 2))
               0:       add_weight = 20;
               1:       add_weight = 45;
               default: add_weight = 70;
            endcase
         end
         send_random_request(add_weight);
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_result_backpressure();
      @(posedge clock);
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 30; i++) send_random_request(50);
   endtask

   // The sender stops until every result is back, then resumes.
   task automatic test_drain_pause();
      for (int i = 0; i < 10; i++) send_random_request(50);
      wait_for_drain();
      for (int i = 0; i < 10; i++) send_random_request(50);
   endtask

   // A burst with no idle cycles on either side.
   task automatic test_back_to_back();
      quiet_mode = 1'b1;
      for (int i = 0; i < 150; i++) send_random_request(45);
      quiet_mode = 1'b0;
   endtask

   // Result side ready: random idling, quiet bursts, and the long hold-off.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_request = hold_request - 1;
      end else if (quiet_mode) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   task automatic report_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                  actual);
         error_count++;
      end
   endtask

   // Each result beat is compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      bat_rsp_beat_type want;
      bat_rsp_beat_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (expected_rsp.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            report_field("hit", int'(want.hit), int'(got.hit));
            report_field("status", int'(want.status), int'(got.status));
            report_field("removed_count", int'(want.removed_count),
                         int'(got.removed_count));
            report_field("entry_count", int'(want.entry_count), int'(got.entry_count));
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
         $display("FAIL breakpoint_address_table");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      error_count      = 0;
      idle_cycles      = 0;
      hold_request     = 0;
      quiet_mode       = 1'b0;
      bp_count         = 0;
      addr_pool[0]     = 16'h0000;
      addr_pool[1]     = 16'hFFFF;
      for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = 16'($urandom);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_sparse_table();
      test_full_table();
      test_random_traffic(500);
      test_result_backpressure();
      test_drain_pause();
      test_back_to_back();
      test_random_traffic(500);

      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS breakpoint_address_table");
      end else begin
         $display("FAIL breakpoint_address_table");
      end
      $finish;
   end

endmodule
